[rtl/rfp_pkg.sv]
// Package for the protocol frame parser: byte codes, phases, event/type/error codes.
// Also the nesting stack command/status structs. No dependencies.
`default_nettype none

package rfp_pkg;

	localparam int MAX_DEPTH = 8;
	localparam int SP_W      = $clog2(MAX_DEPTH + 1);
	localparam int IDX_W     = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	typedef enum logic [3:0] {
		PH_TYPE,
		PH_FIRST,
		PH_NUM,
		PH_NUM_LF,
		PH_LINE,
		PH_LINE_LF,
		PH_BULK,
		PH_BULK_CR,
		PH_BULK_LF
	} phase_t;

	typedef enum logic [1:0] {
		EV_PAYLOAD = 2'd0,
		EV_ELEM    = 2'd1,
		EV_FRAME   = 2'd2,
		EV_ERROR   = 2'd3
	} event_t;

	typedef enum logic [2:0] {
		TY_SIMPLE = 3'd0,
		TY_ERRSTR = 3'd1,
		TY_INT    = 3'd2,
		TY_BULK   = 3'd3,
		TY_ARRAY  = 3'd4
	} elem_type_t;

	typedef enum logic [2:0] {
		ERR_TYPE  = 3'd0,
		ERR_DIGIT = 3'd1,
		ERR_LF    = 3'd2,
		ERR_CR    = 3'd3,
		ERR_DEPTH = 3'd4
	} err_t;

	typedef struct packed {
		logic        clear;
		logic        push;
		logic        finish;
		logic [63:0] count;
	} stk_cmd_t;

	typedef struct packed {
		logic [SP_W-1:0] sp;
		logic            all_done;
	} stk_stat_t;

	function automatic logic [3:0] sat_level(input logic [SP_W-1:0] s);
		if (32'(s) > 32'd15) begin
			return 4'hF;
		end
		return 4'(s);
	endfunction

endpackage

`default_nettype wire

[rtl/rfp_stack.sv]
// Nesting stack of remaining element counts, with the "count is one" flags
// used to find how far a finished element unwinds. Depends on rfp_pkg.
`default_nettype none

module rfp_stack import rfp_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire stk_cmd_t  cmd,
	output stk_stat_t      stat
);

	logic [63:0]          cnt_q [MAX_DEPTH];
	logic [MAX_DEPTH-1:0] one_q;
	logic [SP_W-1:0]      sp_q;

	logic [IDX_W-1:0] keep_idx;
	logic             keep_found;
	logic [63:0]      keep_cnt;

	// highest open level whose count does not run out on this finish
	always_comb begin
		keep_idx   = '0;
		keep_found = 1'b0;
		for (int i = 0; i < MAX_DEPTH; i++) begin
			if ((SP_W'(i) < sp_q) && !one_q[i]) begin
				keep_idx   = IDX_W'(i);
				keep_found = 1'b1;
			end
		end
	end

	assign keep_cnt      = cnt_q[keep_idx];
	assign stat.sp       = sp_q;
	assign stat.all_done = !keep_found;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q <= '0;
		end else if (cmd.clear) begin
			sp_q <= '0;
		end else if (cmd.push) begin
			sp_q <= sp_q + SP_W'(1);
		end else if (cmd.finish) begin
			sp_q <= keep_found ? SP_W'(keep_idx) + SP_W'(1) : '0;
		end
	end

	always_ff @(posedge clk) begin
		if (!cmd.clear && cmd.push) begin
			cnt_q[sp_q[IDX_W-1:0]] <= cmd.count;
			one_q[sp_q[IDX_W-1:0]] <= (cmd.count == 64'd1);
		end else if (!cmd.clear && cmd.finish && keep_found) begin
			cnt_q[keep_idx] <= keep_cnt - 64'd1;
			one_q[keep_idx] <= (keep_cnt == 64'd2);
		end
	end

endmodule

`default_nettype wire

[rtl/resp_frame_parser.sv]
// Protocol frame parser top level: byte input register, combinational step logic, result register.
// Depends on rfp_pkg and rfp_stack.
`default_nettype none
// A byte is registered on acceptance, then stepped; any result is loaded into the result register.
// Throughput: one byte per unstalled cycle; the stack finds the unwind level in the same cycle.
// Reset (arst_n low, async): empty pipeline, frame state cleared, expecting a type byte.
// A result held by res_stall holds the step, and byte_stall rises while a byte waits behind it.

module resp_frame_parser import rfp_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// request side
	input  wire logic               byte_valid,
	output logic                    byte_stall,
	input  wire logic [7:0]         data_byte,
	input  wire logic               restart,
	// result side
	output logic                    res_valid,
	input  wire logic               res_stall,
	output logic [1:0]              event_res,
	output logic [2:0]              elem_type,
	output logic signed [63:0]      value,
	output logic [3:0]              nest_level,
	output logic [7:0]              payload,
	output logic [31:0]             frame_length,
	output logic [2:0]              error_code
);

	// ---------------- input register ----------------
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       restart_s1;

	// ---------------- frame state ----------------
	phase_t      phase_q;
	logic [2:0]  type_q;
	logic        neg_q;
	logic [63:0] acc_q;
	logic [63:0] bulk_q;
	logic [31:0] bc_q;
	logic [2:0]  top_type_q;
	logic [63:0] top_val_q;

	// ---------------- result register ----------------
	logic        res_valid_q;
	logic [1:0]  ev_q;
	logic [2:0]  ty_q;
	logic [63:0] val_q;
	logic [3:0]  lvl_q;
	logic [7:0]  pay_q;
	logic [31:0] flen_q;
	logic [2:0]  err_q;

	// output register free or drained this edge
	logic advance;
	logic step;
	assign advance    = !res_valid_q || !res_stall;
	assign step       = valid_s1 && advance;
	assign byte_stall = valid_s1 && !advance;

	stk_cmd_t  stk_cmd;
	stk_stat_t stk_stat;

	rfp_stack u_stack (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (stk_cmd),
		.stat   (stk_stat)
	);

	// ---------------- step logic ----------------
	// restart folds in as a cleared frame ahead of the byte
	phase_t          cur_phase;
	logic [2:0]      cur_type;
	logic            cur_neg;
	logic [63:0]     cur_acc;
	logic [SP_W-1:0] cur_sp;
	logic [31:0]     bc_inc;
	logic [2:0]      cur_top_type;
	logic [63:0]     cur_top_val;

	phase_t      nx_phase;
	logic [2:0]  nx_type;
	logic        nx_neg;
	logic [63:0] nx_acc;
	logic [63:0] nx_bulk;
	logic [31:0] nx_bc;
	logic [2:0]  nx_top_type;
	logic [63:0] nx_top_val;

	logic        r_valid;
	logic [1:0]  r_ev;
	logic [2:0]  r_ty;
	logic [63:0] r_val;
	logic [3:0]  r_lvl;
	logic [7:0]  r_pay;
	logic [31:0] r_flen;
	logic [2:0]  r_err;

	logic        is_digit;
	logic [63:0] acc_mac;
	logic [63:0] num_v;
	logic        num_pos;
	logic        do_fail;
	logic [2:0]  fail_code;
	logic        do_finish;
	logic [2:0]  fin_type;
	logic [63:0] fin_val;

	always_comb begin
		cur_phase    = restart_s1 ? PH_TYPE : phase_q;
		cur_type     = restart_s1 ? 3'd0 : type_q;
		cur_neg      = restart_s1 ? 1'b0 : neg_q;
		cur_acc      = restart_s1 ? 64'd0 : acc_q;
		cur_sp       = restart_s1 ? '0 : stk_stat.sp;
		cur_top_type = restart_s1 ? 3'd0 : top_type_q;
		cur_top_val  = restart_s1 ? 64'd0 : top_val_q;
		bc_inc       = restart_s1 ? 32'd1 :
		               ((bc_q == 32'hFFFF_FFFF) ? bc_q : bc_q + 32'd1);

		is_digit = (byte_s1 >= CH_ZERO) && (byte_s1 <= CH_NINE);
		acc_mac  = (cur_acc << 3) + (cur_acc << 1) + 64'(byte_s1 - CH_ZERO);
		num_v    = cur_neg ? (64'd0 - cur_acc) : cur_acc;
		num_pos  = (num_v != 64'd0) && !num_v[63];

		nx_phase    = cur_phase;
		nx_type     = cur_type;
		nx_neg      = cur_neg;
		nx_acc      = cur_acc;
		nx_bulk     = restart_s1 ? 64'd0 : bulk_q;
		nx_bc       = bc_inc;
		nx_top_type = cur_top_type;
		nx_top_val  = cur_top_val;

		stk_cmd       = '0;
		stk_cmd.clear = restart_s1;
		stk_cmd.count = num_v;

		r_valid = 1'b0;
		r_ev    = EV_PAYLOAD;
		r_ty    = cur_type;
		r_val   = 64'd0;
		r_lvl   = sat_level(cur_sp);
		r_pay   = 8'd0;
		r_flen  = 32'd0;
		r_err   = ERR_TYPE;

		do_fail   = 1'b0;
		fail_code = ERR_TYPE;
		do_finish = 1'b0;
		fin_type  = cur_type;
		fin_val   = 64'd0;

		unique case (cur_phase)
			PH_TYPE: begin
				case (byte_s1)
					CH_PLUS:   nx_type = TY_SIMPLE;
					CH_MINUS:  nx_type = TY_ERRSTR;
					CH_COLON:  nx_type = TY_INT;
					CH_DOLLAR: nx_type = TY_BULK;
					CH_STAR:   nx_type = TY_ARRAY;
					default: begin
						do_fail   = 1'b1;
						fail_code = ERR_TYPE;
					end
				endcase
				nx_neg = 1'b0;
				nx_acc = 64'd0;
				if (cur_sp == '0) begin
					nx_top_type = nx_type;
					nx_top_val  = 64'd0;
				end
				nx_phase = (nx_type == TY_SIMPLE || nx_type == TY_ERRSTR) ? PH_LINE : PH_FIRST;
			end
			PH_FIRST, PH_NUM: begin
				nx_phase = PH_NUM;
				if (cur_phase == PH_FIRST && byte_s1 == CH_MINUS) begin
					nx_neg = 1'b1;
				end else if (byte_s1 == CH_CR) begin
					nx_phase = PH_NUM_LF;
				end else if (!is_digit) begin
					do_fail   = 1'b1;
					fail_code = ERR_DIGIT;
				end else begin
					nx_acc = acc_mac;
				end
			end
			PH_NUM_LF: begin
				if (byte_s1 != CH_LF) begin
					do_fail   = 1'b1;
					fail_code = ERR_LF;
				end else begin
					nx_neg = 1'b0;
					nx_acc = num_v;
					if (cur_sp == '0) begin
						nx_top_val = num_v;
					end
					if (cur_type == TY_INT) begin
						do_finish = 1'b1;
						fin_type  = TY_INT;
						fin_val   = num_v;
					end else if (cur_type == TY_BULK) begin
						if (num_pos) begin
							nx_bulk  = num_v;
							nx_phase = PH_BULK;
						end else begin
							nx_phase = PH_BULK_CR;
						end
					end else if (!num_pos) begin
						do_finish = 1'b1;
						fin_type  = TY_ARRAY;
						fin_val   = num_v;
					end else if (cur_sp >= SP_W'(MAX_DEPTH)) begin
						do_fail   = 1'b1;
						fail_code = ERR_DEPTH;
					end else begin
						stk_cmd.push = 1'b1;
						nx_phase     = PH_TYPE;
					end
				end
			end
			PH_BULK: begin
				r_valid = 1'b1;
				r_ev    = EV_PAYLOAD;
				r_pay   = byte_s1;
				nx_bulk = nx_bulk - 64'd1;
				if (nx_bulk == 64'd0) begin
					nx_phase = PH_BULK_CR;
				end
			end
			PH_BULK_CR: begin
				if (byte_s1 != CH_CR) begin
					do_fail   = 1'b1;
					fail_code = ERR_CR;
				end else begin
					nx_phase = PH_BULK_LF;
				end
			end
			PH_BULK_LF: begin
				if (byte_s1 != CH_LF) begin
					do_fail   = 1'b1;
					fail_code = ERR_LF;
				end else begin
					do_finish = 1'b1;
					fin_type  = TY_BULK;
					fin_val   = cur_acc;
				end
			end
			PH_LINE: begin
				if (byte_s1 == CH_CR) begin
					nx_phase = PH_LINE_LF;
				end else begin
					r_valid = 1'b1;
					r_ev    = EV_PAYLOAD;
					r_pay   = byte_s1;
				end
			end
			PH_LINE_LF: begin
				if (byte_s1 != CH_LF) begin
					do_fail   = 1'b1;
					fail_code = ERR_LF;
				end else begin
					do_finish = 1'b1;
					fin_type  = cur_type;
					fin_val   = 64'd0;
				end
			end
			default: begin
				nx_phase    = PH_TYPE;
				nx_type     = 3'd0;
				nx_neg      = 1'b0;
				nx_acc      = 64'd0;
				nx_bulk     = 64'd0;
				nx_bc       = 32'd0;
				nx_top_type = 3'd0;
				nx_top_val  = 64'd0;
				stk_cmd.clear = 1'b1;
			end
		endcase

		// finishing an element: either an enclosing array still has members,
		// or the whole frame closes and the top-level element is reported
		if (do_finish) begin
			r_valid = 1'b1;
			if (!stk_stat.all_done && !restart_s1) begin
				r_ev           = EV_ELEM;
				r_ty           = fin_type;
				r_val          = fin_val;
				nx_phase       = PH_TYPE;
				stk_cmd.finish = 1'b1;
			end else begin
				r_ev        = EV_FRAME;
				r_ty        = nx_top_type;
				r_val       = nx_top_val;
				r_lvl       = 4'd0;
				r_flen      = bc_inc;
				nx_phase    = PH_TYPE;
				nx_type     = 3'd0;
				nx_neg      = 1'b0;
				nx_acc      = 64'd0;
				nx_bulk     = 64'd0;
				nx_bc       = 32'd0;
				nx_top_type = 3'd0;
				nx_top_val  = 64'd0;
				stk_cmd.clear = 1'b1;
			end
		end

		// any error drops the partial frame; a bad type byte reports type zero
		if (do_fail) begin
			r_valid     = 1'b1;
			r_ev        = EV_ERROR;
			r_ty        = (cur_phase == PH_TYPE) ? 3'd0 : cur_type;
			r_val       = 64'd0;
			r_lvl       = sat_level(cur_sp);
			r_pay       = byte_s1;
			r_flen      = 32'd0;
			r_err       = fail_code;
			nx_phase    = PH_TYPE;
			nx_type     = 3'd0;
			nx_neg      = 1'b0;
			nx_acc      = 64'd0;
			nx_bulk     = 64'd0;
			nx_bc       = 32'd0;
			nx_top_type = 3'd0;
			nx_top_val  = 64'd0;
			stk_cmd.clear  = 1'b1;
			stk_cmd.push   = 1'b0;
			stk_cmd.finish = 1'b0;
		end

		// nothing moves unless the step is taken this cycle
		if (!step) begin
			stk_cmd.clear  = 1'b0;
			stk_cmd.push   = 1'b0;
			stk_cmd.finish = 1'b0;
		end
	end

	// ---------------- registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!byte_stall) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!byte_stall && byte_valid) begin
			byte_s1    <= data_byte;
			restart_s1 <= restart;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_TYPE;
			type_q     <= 3'd0;
			neg_q      <= 1'b0;
			acc_q      <= 64'd0;
			bulk_q     <= 64'd0;
			bc_q       <= 32'd0;
			top_type_q <= 3'd0;
			top_val_q  <= 64'd0;
		end else if (step) begin
			phase_q    <= nx_phase;
			type_q     <= nx_type;
			neg_q      <= nx_neg;
			acc_q      <= nx_acc;
			bulk_q     <= nx_bulk;
			bc_q       <= nx_bc;
			top_type_q <= nx_top_type;
			top_val_q  <= nx_top_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= step && r_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (step && r_valid) begin
			ev_q   <= r_ev;
			ty_q   <= r_ty;
			val_q  <= r_val;
			lvl_q  <= r_lvl;
			pay_q  <= r_pay;
			flen_q <= r_flen;
			err_q  <= r_err;
		end
	end

	assign res_valid    = res_valid_q;
	assign event_res    = ev_q;
	assign elem_type    = ty_q;
	assign value        = val_q;
	assign nest_level   = lvl_q;
	assign payload      = pay_q;
	assign frame_length = flen_q;
	assign error_code   = err_q;

endmodule

`default_nettype wire

[tb/testbench.sv]
// Self-checking bench for resp_frame_parser: random protocol frames in, each result checked.
// Depends on rfp_pkg (byte codes, event/type/error enums, MAX_DEPTH) and the parser RTL.
`default_nettype none

module testbench;
	import rfp_pkg::*;

	localparam int N_BYTES     = 1950;
	localparam int IDLE_LIMIT  = 1000;   // cycles with no handshake on either side
	localparam int TAIL_CYCLES = 10;     // cycles run on after the last expected result

	// one request: a stream byte plus the restart flag, the idle cycles in front
	// of it, and whether the sender holds it back until all results are in
	typedef struct {
		logic [7:0] data;
		logic       rs;
		int         gap;
		bit         drain;
	} byte_req_t;

	typedef struct {
		event_t      ev;
		elem_type_t  ty;
		logic [63:0] val;
		logic [3:0]  lvl;
		logic [7:0]  pay;
		logic [31:0] flen;
		err_t        err;
	} parse_evt_t;

	logic              clk        = 1'b0;
	logic              arst_n     = 1'b0;
	logic              byte_valid = 1'b0;
	logic              byte_stall;
	logic [7:0]        data_byte  = 8'h00;
	logic              restart    = 1'b0;
	logic              res_valid;
	logic              res_stall  = 1'b0;
	logic [1:0]        event_res;
	logic [2:0]        elem_type;
	logic signed [63:0] value;
	logic [3:0]        nest_level;
	logic [7:0]        payload;
	logic [31:0]       frame_length;
	logic [2:0]        error_code;

	resp_frame_parser dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (byte_valid),
		.byte_stall   (byte_stall),
		.data_byte    (data_byte),
		.restart      (restart),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.event_res    (event_res),
		.elem_type    (elem_type),
		.value        (value),
		.nest_level   (nest_level),
		.payload      (payload),
		.frame_length (frame_length),
		.error_code   (error_code)
	);

	byte_req_t  pending_bytes[$];
	parse_evt_t expected_events[$];
	int         fail_cnt  = 0;
	int         res_count = 0;
	int         idle_run  = 0;
	int         stall_left;

	// stimulus shaping knobs, only touched while the queue is filled
	bit snd_quiet  = 1'b0;
	bit rs_next    = 1'b0;
	bit corrupting = 1'b0;
	int drain_mark = 500;

	// ------------------------------------------------------------------
	// Parser prediction: frame state mirrored at block widths
	// ------------------------------------------------------------------
	phase_t      ps_phase;
	elem_type_t  ps_type;
	elem_type_t  ps_top_type;
	bit          ps_neg;
	logic [63:0] ps_acc;
	logic [63:0] ps_bulk_left;
	logic [63:0] ps_top_val;
	int          ps_depth;
	logic [63:0] ps_counts[MAX_DEPTH];
	logic [31:0] ps_nbytes;

	task automatic frame_clear();
		ps_phase     = PH_TYPE;
		ps_type      = TY_SIMPLE;
		ps_top_type  = TY_SIMPLE;
		ps_neg       = 1'b0;
		ps_acc       = '0;
		ps_bulk_left = '0;
		ps_top_val   = '0;
		ps_depth     = 0;
		ps_nbytes    = '0;
	endtask

	function automatic parse_evt_t mk_evt(input event_t ev, input elem_type_t ty,
			input logic [63:0] val, input int lvl, input logic [7:0] pay,
			input logic [31:0] flen, input err_t err);
		parse_evt_t e;
		e.ev   = ev;
		e.ty   = ty;
		e.val  = val;
		e.lvl  = (lvl > 15) ? 4'd15 : 4'(lvl);
		e.pay  = pay;
		e.flen = flen;
		e.err  = err;
		return e;
	endfunction

	// error: reported with the type and depth in force, then the frame is dropped
	task automatic parse_fail(input err_t code, input logic [7:0] b, output parse_evt_t e);
		e = mk_evt(EV_ERROR, ps_type, '0, ps_depth, b, '0, code);
		frame_clear();
	endtask

	// an element ended: pop exhausted array counts; innermost open array that
	// still wants elements gets an element-done, else the whole frame is done
	// (error_code reads zero on non-error events, i.e. ERR_TYPE)
	task automatic close_element(input elem_type_t ty, input logic [63:0] val,
			output parse_evt_t e);
		int lvl;
		lvl = ps_depth;
		while (ps_depth > 0) begin
			ps_counts[ps_depth-1] = ps_counts[ps_depth-1] - 64'd1;
			if (ps_counts[ps_depth-1] != '0) begin
				ps_phase = PH_TYPE;
				e = mk_evt(EV_ELEM, ty, val, lvl, '0, '0, ERR_TYPE);
				return;
			end
			ps_depth--;
		end
		e = mk_evt(EV_FRAME, ps_top_type, ps_top_val, 0, '0, ps_nbytes, ERR_TYPE);
		frame_clear();
	endtask

	task automatic parse_byte(input logic [7:0] b, input logic rs, output bit got,
			output parse_evt_t e);
		logic [63:0] v;
		got = 1'b0;
		e = mk_evt(EV_PAYLOAD, TY_SIMPLE, '0, 0, '0, '0, ERR_TYPE);
		if (rs) begin
			frame_clear();
		end
		if (ps_nbytes != '1) begin
			ps_nbytes = ps_nbytes + 32'd1;
		end
		case (ps_phase)
		PH_TYPE: begin
			case (b)
			CH_PLUS:   ps_type = TY_SIMPLE;
			CH_MINUS:  ps_type = TY_ERRSTR;
			CH_COLON:  ps_type = TY_INT;
			CH_DOLLAR: ps_type = TY_BULK;
			CH_STAR:   ps_type = TY_ARRAY;
			default: begin
				ps_type = TY_SIMPLE;
				parse_fail(ERR_TYPE, b, e);
				got = 1'b1;
				return;
			end
			endcase
			ps_neg = 1'b0;
			ps_acc = '0;
			if (ps_depth == 0) begin
				ps_top_type = ps_type;
				ps_top_val  = '0;
			end
			ps_phase = (ps_type == TY_SIMPLE || ps_type == TY_ERRSTR) ? PH_LINE : PH_FIRST;
		end
		PH_FIRST, PH_NUM: begin
			// sign only as the very first number character
			if (ps_phase == PH_FIRST && b == CH_MINUS) begin
				ps_neg   = 1'b1;
				ps_phase = PH_NUM;
			end else begin
				ps_phase = PH_NUM;
				if (b == CH_CR) begin
					ps_phase = PH_NUM_LF;
				end else if (b < CH_ZERO || b > CH_NINE) begin
					parse_fail(ERR_DIGIT, b, e);
					got = 1'b1;
				end else begin
					ps_acc = ps_acc * 64'd10 + 64'(b - CH_ZERO);
				end
			end
		end
		PH_NUM_LF: begin
			if (b != CH_LF) begin
				parse_fail(ERR_LF, b, e);
				got = 1'b1;
			end else begin
				v = ps_neg ? (64'd0 - ps_acc) : ps_acc;
				ps_neg = 1'b0;
				ps_acc = v;
				if (ps_depth == 0) begin
					ps_top_val = v;
				end
				if (ps_type == TY_INT) begin
					close_element(TY_INT, v, e);
					got = 1'b1;
				end else if (ps_type == TY_BULK) begin
					// non-positive length: no payload, CR LF still follows
					if (v != '0 && !v[63]) begin
						ps_bulk_left = v;
						ps_phase     = PH_BULK;
					end else begin
						ps_phase = PH_BULK_CR;
					end
				end else if (v == '0 || v[63]) begin
					close_element(TY_ARRAY, v, e);
					got = 1'b1;
				end else if (ps_depth >= MAX_DEPTH) begin
					parse_fail(ERR_DEPTH, b, e);
					got = 1'b1;
				end else begin
					ps_counts[ps_depth] = v;
					ps_depth++;
					ps_phase = PH_TYPE;
				end
			end
		end
		PH_BULK: begin
			e = mk_evt(EV_PAYLOAD, ps_type, '0, ps_depth, b, '0, ERR_TYPE);
			got = 1'b1;
			ps_bulk_left = ps_bulk_left - 64'd1;
			if (ps_bulk_left == '0) begin
				ps_phase = PH_BULK_CR;
			end
		end
		PH_BULK_CR: begin
			if (b != CH_CR) begin
				parse_fail(ERR_CR, b, e);
				got = 1'b1;
			end else begin
				ps_phase = PH_BULK_LF;
			end
		end
		PH_BULK_LF: begin
			if (b != CH_LF) begin
				parse_fail(ERR_LF, b, e);
			end else begin
				close_element(TY_BULK, ps_acc, e);
			end
			got = 1'b1;
		end
		PH_LINE: begin
			if (b == CH_CR) begin
				ps_phase = PH_LINE_LF;
			end else begin
				e = mk_evt(EV_PAYLOAD, ps_type, '0, ps_depth, b, '0, ERR_TYPE);
				got = 1'b1;
			end
		end
		PH_LINE_LF: begin
			if (b != CH_LF) begin
				parse_fail(ERR_LF, b, e);
			end else begin
				close_element(ps_type, '0, e);
			end
			got = 1'b1;
		end
		default: frame_clear();
		endcase
	endtask

	// ------------------------------------------------------------------
	// Stream generation into the request queue
	// ------------------------------------------------------------------
	task automatic push_req(input logic [7:0] b);
		byte_req_t r;
		// broken frames: now and then a byte is swapped for a delimiter or junk
		if (corrupting && $urandom_range(0, 11) == 0) begin
			case ($urandom_range(0, 3))
			0: b = CH_CR;
			1: b = CH_LF;
			2: b = 8'($urandom_range(0, 255));
			default: b = b ^ (8'h01 << $urandom_range(0, 7));
			endcase
		end
		r.data  = b;
		r.rs    = rs_next || ($urandom_range(0, 199) == 0);
		rs_next = 1'b0;
		r.gap   = snd_quiet ? 0 : $urandom_range(0, 5);
		r.drain = 1'b0;
		if (pending_bytes.size() >= drain_mark) begin
			r.drain    = 1'b1;
			drain_mark = drain_mark + 600;
		end
		pending_bytes.push_back(r);
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++) begin
			push_req(s[i]);
		end
	endtask

	task automatic push_crlf();
		push_req(CH_CR);
		push_req(CH_LF);
	endtask

	// decimal text for an integer element: empty, bare sign, small, leading
	// zeros, random 32-bit values, long digit runs that wrap, and the 64-bit edges
	function automatic string num_text();
		string s;
		case ($urandom_range(0, 7))
		0: s = "";
		1: s = "-";
		2: s = $sformatf("%0d", $urandom_range(0, 99));
		3: s = $sformatf("-%0d", $urandom_range(0, 99));
		4: s = $sformatf("00%0d", $urandom_range(0, 9));
		5: s = $sformatf("%0d", $urandom());
		6: begin
			s = ($urandom_range(0, 1) != 0) ? "-" : "";
			repeat ($urandom_range(18, 21)) begin
				s = $sformatf("%s%0d", s, $urandom_range(0, 9));
			end
		end
		default: begin
			case ($urandom_range(0, 3))
			0: s = "9223372036854775807";
			1: s = "9223372036854775808";
			2: s = "18446744073709551615";
			default: s = "-9223372036854775808";
			endcase
		end
		endcase
		return s;
	endfunction

	// length/count text that comes out non-positive
	function automatic string nonpos_text();
		case ($urandom_range(0, 4))
		0: return "0";
		1: return "-1";
		2: return "";
		3: return "-";
		default: return "-4294967297";
		endcase
	endfunction

	// one well-formed element; from level 4 on only leaves are made
	task automatic gen_element(input int lvl);
		int    k;
		int    n;
		logic [7:0] b;
		k = $urandom_range(0, 9);
		if (k >= 7 && lvl >= 4) begin
			k = $urandom_range(0, 6);
		end
		case (k)
		0, 1, 2: begin
			push_req((k == 2) ? CH_MINUS : CH_PLUS);
			repeat ($urandom_range(0, 6)) begin
				b = 8'($urandom_range(0, 255));
				push_req((b == CH_CR) ? CH_LF : b);
			end
			push_crlf();
		end
		3, 4: begin
			push_req(CH_COLON);
			push_text(num_text());
			push_crlf();
		end
		5, 6: begin
			push_req(CH_DOLLAR);
			if ($urandom_range(0, 9) < 7) begin
				n = $urandom_range(1, 6);
				push_text($sformatf("%0d", n));
			end else begin
				n = 0;
				push_text(nonpos_text());
			end
			push_crlf();
			// payload is raw: delimiters inside it are plain content
			repeat (n) begin
				case ($urandom_range(0, 3))
				0: push_req(CH_CR);
				1: push_req(CH_LF);
				default: push_req(8'($urandom_range(0, 255)));
				endcase
			end
			push_crlf();
		end
		default: begin
			push_req(CH_STAR);
			if ($urandom_range(0, 5) != 0) begin
				n = $urandom_range(0, 3);
				push_text($sformatf("%0d", n));
			end else begin
				n = 0;
				push_text(nonpos_text());
			end
			push_crlf();
			repeat (n) begin
				gen_element(lvl + 1);
			end
		end
		endcase
	endtask

	// ------------------------------------------------------------------
	// Clock and reset
	// ------------------------------------------------------------------
	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// ------------------------------------------------------------------
	// Request driver: presents queued bytes, predicts each accepted one
	// ------------------------------------------------------------------
	byte_req_t  drv_next;
	bit         drv_got;
	parse_evt_t drv_evt;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_valid <= 1'b0;
			data_byte  <= 8'h00;
			restart    <= 1'b0;
			frame_clear();
			foreach (ps_counts[i]) begin
				ps_counts[i] = '0;
			end
		end else begin
			if (byte_valid && !byte_stall) begin
				parse_byte(data_byte, restart, drv_got, drv_evt);
				if (drv_got) begin
					expected_events.push_back(drv_evt);
				end
			end
			// payload only moves once the current request is gone
			if (!byte_valid || !byte_stall) begin
				if (pending_bytes.size() == 0) begin
					byte_valid <= 1'b0;
				end else if (pending_bytes[0].drain && expected_events.size() != 0) begin
					// hold-off: let the result side run dry first
					byte_valid <= 1'b0;
				end else if (pending_bytes[0].gap != 0) begin
					pending_bytes[0].gap = pending_bytes[0].gap - 1;
					byte_valid <= 1'b0;
				end else begin
					drv_next = pending_bytes.pop_front();
					byte_valid <= 1'b1;
					data_byte  <= drv_next.data;
					restart    <= drv_next.rs;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Result monitor: random stall, in-order compare against predictions
	// ------------------------------------------------------------------
	parse_evt_t mon_exp;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_stall <= 1'b0;
			stall_left = 0;
		end else begin
			if (res_valid && !res_stall) begin
				res_count++;
				if (expected_events.size() == 0) begin
					fail_cnt++;
					if (fail_cnt <= 10) begin
						$display("unexpected result: ev=%0d ty=%0d val=%h lvl=%0d pay=%h",
							event_res, elem_type, value, nest_level, payload);
					end
				end else begin
					mon_exp = expected_events.pop_front();
					if (event_res !== mon_exp.ev || elem_type !== mon_exp.ty
							|| value !== mon_exp.val || nest_level !== mon_exp.lvl
							|| payload !== mon_exp.pay || frame_length !== mon_exp.flen
							|| error_code !== mon_exp.err) begin
						fail_cnt++;
						if (fail_cnt <= 10) begin
							$display("mismatch #%0d exp ev=%0d ty=%0d val=%h lvl=%0d pay=%h len=%0d err=%0d | got ev=%0d ty=%0d val=%h lvl=%0d pay=%h len=%0d err=%0d",
								res_count, mon_exp.ev, mon_exp.ty, mon_exp.val, mon_exp.lvl,
								mon_exp.pay, mon_exp.flen, mon_exp.err, event_res, elem_type,
								value, nest_level, payload, frame_length, error_code);
						end
					end
				end
				// every third stretch of results goes through unstalled
				stall_left = ((res_count / 150) % 3 == 2) ? 0 : $urandom_range(0, 5);
			end
			if (stall_left != 0) begin
				stall_left--;
				res_stall <= 1'b1;
			end else begin
				res_stall <= 1'b0;
			end
		end
	end

	// watchdog: a correct run never goes this long without a handshake
	always @(posedge clk) begin
		if (arst_n) begin
			if ((byte_valid && !byte_stall) || (res_valid && !res_stall)) begin
				idle_run = 0;
			end else begin
				idle_run++;
			end
			if (idle_run == IDLE_LIMIT) begin
				$display("** resp_frame_parser: FAILED **");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus: directed stream, then random frames; then wait for the end
	// ------------------------------------------------------------------
	int sel;

	initial begin
		// bad type bytes at both ends of the byte range
		push_req(8'h00);
		push_req(8'hFF);
		push_text("+A");
		push_crlf();
		// empty error string, then empty negative number reads as zero
		push_text("-");
		push_crlf();
		push_text(":-");
		push_crlf();
		// bulk payload that is itself CR LF
		push_text("$2");
		push_crlf();
		push_crlf();
		push_crlf();
		// empty array inside a one-element array closes both at once
		push_text("*1");
		push_crlf();
		push_text("*0");
		push_crlf();

		while (pending_bytes.size() < N_BYTES) begin
			if ($urandom_range(0, 9) == 0) begin
				snd_quiet = !snd_quiet;
			end
			if ($urandom_range(0, 3) == 0) begin
				rs_next = 1'b1;
			end
			sel = $urandom_range(0, 19);
			if (sel < 14) begin
				gen_element(0);
			end else if (sel < 16) begin
				// nesting chain, sometimes one level past the stack depth
				repeat ($urandom_range(5, MAX_DEPTH + 1)) begin
					push_text("*1");
					push_crlf();
				end
				gen_element(MAX_DEPTH);
			end else if (sel < 18) begin
				corrupting = 1'b1;
				gen_element(0);
				corrupting = 1'b0;
				rs_next = 1'b1;
			end else begin
				repeat ($urandom_range(1, 8)) begin
					push_req(8'($urandom_range(0, 255)));
				end
				rs_next = 1'b1;
			end
		end

		wait (arst_n);
		while (pending_bytes.size() != 0 || byte_valid) begin
			@(posedge clk);
		end
		while (expected_events.size() != 0) begin
			@(posedge clk);
		end
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_cnt == 0) begin
			$display("** resp_frame_parser: PASSED **");
		end else begin
			$display("** resp_frame_parser: FAILED **");
		end
		$finish;
	end

endmodule

`default_nettype wire
